### src/der_ecdsa_signature_canonical_check_defines.svh
// Assertion macros shared by the DER signature checker modules.
`ifndef DER_ECDSA_SIGNATURE_CANONICAL_CHECK_DEFINES_SVH
`define DER_ECDSA_SIGNATURE_CANONICAL_CHECK_DEFINES_SVH

// Same-cycle implication, off while reset is held.
`define DERCC_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("dercc assertion failed");

// Next-cycle implication, off while reset is held.
`define DERCC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("dercc assertion failed");

`endif

### src/dercc_pkg.sv
// Types, codes and curve constants for the DER signature checker.
`timescale 1ns / 1ps
package dercc_pkg;

  localparam int unsigned MAX_SIG_BYTES  = 72;
  localparam int unsigned MIN_SIG_BYTES  = 8;
  localparam int unsigned MAX_PART_BYTES = 33;
  localparam int unsigned INT_BYTES      = 33;

  localparam logic [7:0] SEQ_TAG = 8'h30;
  localparam logic [7:0] INT_TAG = 8'h02;

  typedef enum logic [1:0] {
    CMP_EQ = 2'd0,
    CMP_LT = 2'd1,
    CMP_GT = 2'd2
  } cmp_t;

  typedef enum logic [1:0] {
    VERDICT_BAD    = 2'd0,
    VERDICT_HIGH_S = 2'd1,
    VERDICT_LOW_S  = 2'd2
  } verdict_t;

  typedef enum logic [8:0] {
    PH_SEQ   = 9'b000000001,
    PH_TOTAL = 9'b000000010,
    PH_R_TAG = 9'b000000100,
    PH_R_LEN = 9'b000001000,
    PH_R_VAL = 9'b000010000,
    PH_S_TAG = 9'b000100000,
    PH_S_LEN = 9'b001000000,
    PH_S_VAL = 9'b010000000,
    PH_DONE  = 9'b100000000
  } phase_t;

  // Group order and (order-1)/2 as 33-byte big-endian numbers.
  localparam logic [7:0] ORDER_G [INT_BYTES] = '{
    8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFE, 8'hBA, 8'hAE, 8'hDC, 8'hE6, 8'hAF,
    8'h48, 8'hA0, 8'h3B, 8'hBF, 8'hD2, 8'h5E, 8'h8C, 8'hD0, 8'h36, 8'h41, 8'h41
  };
  localparam logic [7:0] HALF_G [INT_BYTES] = '{
    8'h00, 8'h7F, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h5D, 8'h57, 8'h6E, 8'h73, 8'h57,
    8'hA4, 8'h50, 8'h1D, 8'hDF, 8'hE9, 8'h2F, 8'h46, 8'h68, 8'h1B, 8'h20, 8'hA0
  };

  // Running most-significant-first compare: first unequal byte decides.
  function automatic cmp_t cmp_next(cmp_t cur, logic [7:0] ref_byte,
                                    logic [5:0] rem, logic [7:0] b);
    cmp_t res;
    res = cur;
    if (cur == CMP_EQ && rem != 6'd0 && rem <= 6'(INT_BYTES)) begin
      if (b < ref_byte) begin
        res = CMP_LT;
      end else if (b > ref_byte) begin
        res = CMP_GT;
      end
    end
    return res;
  endfunction

endpackage

### src/dercc_parse.sv
// Byte-wise DER parser and range compare state for one signature.
`timescale 1ns / 1ps
`include "der_ecdsa_signature_canonical_check_defines.svh"
module dercc_parse (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [7:0]          sig_byte,
  input  logic                last_byte,
  output dercc_pkg::verdict_t verdict
);

  dercc_pkg::phase_t phase_r, phase_nxt;
  logic [6:0]        cnt_r, cnt_nxt;
  logic [7:0]        total_r, total_nxt;
  logic [5:0]        rem_r, rem_nxt;
  logic [5:0]        len_r, len_nxt;
  logic              mal_r, mal_nxt;
  logic              lz_r, lz_nxt;
  dercc_pkg::cmp_t   r_ord_r, r_ord_nxt;
  dercc_pkg::cmp_t   s_ord_r, s_ord_nxt;
  dercc_pkg::cmp_t   s_half_r, s_half_nxt;

  logic            is_s;
  logic            first_val;
  logic            second_val;
  logic            bad_val;
  logic [5:0]      rem_dec;
  logic [5:0]      tab_idx;
  dercc_pkg::cmp_t start_cmp;
  logic            sig_ok;

  assign tab_idx   = 6'(dercc_pkg::INT_BYTES - int'(rem_r));
  assign start_cmp = (sig_byte >= 8'd32) ? dercc_pkg::CMP_EQ : dercc_pkg::CMP_LT;
  assign first_val  = (rem_r == len_r);
  assign second_val = ({1'b0, rem_r} + 7'd1) == {1'b0, len_r};
  assign bad_val    = first_val ? (sig_byte[7] || (sig_byte == 8'd0 && len_r == 6'd1))
                                : (second_val && lz_r && !sig_byte[7]);
  assign rem_dec    = (rem_r != 6'd0) ? rem_r - 6'd1 : rem_r;

  always_comb begin
    phase_nxt  = phase_r;
    total_nxt  = total_r;
    rem_nxt    = rem_r;
    len_nxt    = len_r;
    lz_nxt     = lz_r;
    r_ord_nxt  = r_ord_r;
    s_ord_nxt  = s_ord_r;
    s_half_nxt = s_half_r;
    is_s       = (phase_r == dercc_pkg::PH_S_VAL) || (phase_r == dercc_pkg::PH_S_LEN);

    // Saturate the count one past the limit; that alone marks it malformed.
    cnt_nxt = (cnt_r < 7'(dercc_pkg::MAX_SIG_BYTES + 1)) ? cnt_r + 7'd1 : cnt_r;
    mal_nxt = mal_r || (cnt_nxt > 7'(dercc_pkg::MAX_SIG_BYTES));

    if (!mal_nxt) begin
      case (phase_r)
        dercc_pkg::PH_SEQ: begin
          if (sig_byte != dercc_pkg::SEQ_TAG) mal_nxt = 1'b1;
          else phase_nxt = dercc_pkg::PH_TOTAL;
        end
        dercc_pkg::PH_TOTAL: begin
          total_nxt = sig_byte;
          phase_nxt = dercc_pkg::PH_R_TAG;
        end
        dercc_pkg::PH_R_TAG: begin
          if (sig_byte != dercc_pkg::INT_TAG) mal_nxt = 1'b1;
          else phase_nxt = dercc_pkg::PH_R_LEN;
        end
        dercc_pkg::PH_S_TAG: begin
          if (sig_byte != dercc_pkg::INT_TAG) mal_nxt = 1'b1;
          else phase_nxt = dercc_pkg::PH_S_LEN;
        end
        dercc_pkg::PH_R_LEN, dercc_pkg::PH_S_LEN: begin
          if (sig_byte == 8'd0 || sig_byte > 8'(dercc_pkg::MAX_PART_BYTES)) begin
            mal_nxt = 1'b1;
          end else begin
            len_nxt = sig_byte[5:0];
            rem_nxt = sig_byte[5:0];
            lz_nxt  = 1'b0;
            if (is_s) begin
              s_ord_nxt  = start_cmp;
              s_half_nxt = start_cmp;
              phase_nxt  = dercc_pkg::PH_S_VAL;
            end else begin
              r_ord_nxt = start_cmp;
              phase_nxt = dercc_pkg::PH_R_VAL;
            end
          end
        end
        dercc_pkg::PH_R_VAL, dercc_pkg::PH_S_VAL: begin
          if (bad_val) begin
            mal_nxt = 1'b1;
          end else begin
            if (first_val) lz_nxt = (sig_byte == 8'd0);
            if (is_s) begin
              s_ord_nxt  = dercc_pkg::cmp_next(s_ord_r, dercc_pkg::ORDER_G[tab_idx],
                                               rem_r, sig_byte);
              s_half_nxt = dercc_pkg::cmp_next(s_half_r, dercc_pkg::HALF_G[tab_idx],
                                               rem_r, sig_byte);
            end else begin
              r_ord_nxt = dercc_pkg::cmp_next(r_ord_r, dercc_pkg::ORDER_G[tab_idx],
                                              rem_r, sig_byte);
            end
            rem_nxt = rem_dec;
            if (rem_dec == 6'd0) begin
              phase_nxt = is_s ? dercc_pkg::PH_DONE : dercc_pkg::PH_S_TAG;
            end
          end
        end
        default: begin
          // Any byte after S, or a lost phase code.
          mal_nxt = 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    sig_ok = !mal_nxt && (phase_nxt == dercc_pkg::PH_DONE) &&
             (cnt_nxt >= 7'(dercc_pkg::MIN_SIG_BYTES)) &&
             (cnt_nxt <= 7'(dercc_pkg::MAX_SIG_BYTES)) &&
             (({1'b0, total_nxt} + 9'd2) == {2'b00, cnt_nxt}) &&
             (r_ord_nxt == dercc_pkg::CMP_LT) && (s_ord_nxt == dercc_pkg::CMP_LT);
    if (!sig_ok) verdict = dercc_pkg::VERDICT_BAD;
    else if (s_half_nxt == dercc_pkg::CMP_GT) verdict = dercc_pkg::VERDICT_HIGH_S;
    else verdict = dercc_pkg::VERDICT_LOW_S;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && last_byte)) begin
      // The final byte of a signature starts the next one from scratch.
      phase_r  <= dercc_pkg::PH_SEQ;
      cnt_r    <= 7'd0;
      total_r  <= 8'd0;
      rem_r    <= 6'd0;
      len_r    <= 6'd0;
      mal_r    <= 1'b0;
      lz_r     <= 1'b0;
      r_ord_r  <= dercc_pkg::CMP_EQ;
      s_ord_r  <= dercc_pkg::CMP_EQ;
      s_half_r <= dercc_pkg::CMP_EQ;
    end else if (step) begin
      phase_r  <= phase_nxt;
      cnt_r    <= cnt_nxt;
      total_r  <= total_nxt;
      rem_r    <= rem_nxt;
      len_r    <= len_nxt;
      mal_r    <= mal_nxt;
      lz_r     <= lz_nxt;
      r_ord_r  <= r_ord_nxt;
      s_ord_r  <= s_ord_nxt;
      s_half_r <= s_half_nxt;
    end
  end

  `DERCC_ASSERT_NEXT(a_restart_after_last, clk, rst_n, step && last_byte,
                     phase_r == dercc_pkg::PH_SEQ && cnt_r == 7'd0 && !mal_r)
  `DERCC_ASSERT_IMPL(a_count_saturates, clk, rst_n, 1'b1,
                     cnt_r <= 7'(dercc_pkg::MAX_SIG_BYTES + 1))
  `DERCC_ASSERT_IMPL(a_value_bytes_pending, clk, rst_n,
                     phase_r == dercc_pkg::PH_R_VAL || phase_r == dercc_pkg::PH_S_VAL,
                     rem_r != 6'd0 && rem_r <= len_r)

endmodule

### src/der_ecdsa_signature_canonical_check.sv
// Top level: strict DER ECDSA signature check with low-S verdict.
//
// Usage:
//   Feed a DER-encoded secp256k1 signature on the in_ channel, one byte per
//   transfer, with in_last_byte high on the final byte. Every signature gives
//   exactly one verdict on the out_ channel, at its final byte:
//     0 malformed or R/S not below the group order,
//     1 canonical encoding with S above half the order,
//     2 fully canonical (S at most half the order).
//   Bytes pass an input register and the parse/compare state updates once per
//   byte, so one byte is taken every cycle unless a final byte waits for the
//   output register. The verdict is registered in the output register when the
//   final byte leaves the input register, later only while an earlier verdict
//   still waits in the output register.
//   If the receiver stalls, the verdict is held; the next signature's bytes
//   keep flowing until another final byte needs the output register.
//   Reset (rst_n low, synchronous) empties both registers and returns the
//   parser to expect the sequence tag.
`timescale 1ns / 1ps
`include "der_ecdsa_signature_canonical_check_defines.svh"
module der_ecdsa_signature_canonical_check (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_sig_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_verdict
);

  logic                in_v_r;
  logic [7:0]          in_byte_r;
  logic                in_last_r;
  logic                out_v_r;
  logic [1:0]          out_verdict_r;
  logic                adv;
  dercc_pkg::verdict_t verdict;

  // A non-final byte never waits; a final one needs a free output slot.
  assign adv      = in_v_r && (!in_last_r || !out_v_r || out_ready);
  assign in_ready = !in_v_r || adv;

  dercc_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (adv),
    .sig_byte  (in_byte_r),
    .last_byte (in_last_r),
    .verdict   (verdict)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_ready) in_v_r <= in_valid;
      if (adv && in_last_r) out_v_r <= 1'b1;
      else if (out_ready) out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_sig_byte;
      in_last_r <= in_last_byte;
    end
    if (adv && in_last_r) out_verdict_r <= verdict;
  end

  assign out_valid   = out_v_r;
  assign out_verdict = out_verdict_r;

  `DERCC_ASSERT_IMPL(a_verdict_code, clk, rst_n, out_v_r, out_verdict_r != 2'd3)
  `DERCC_ASSERT_IMPL(a_middle_never_stalls, clk, rst_n, in_v_r && !in_last_r, adv)
  `DERCC_ASSERT_NEXT(a_last_gives_result, clk, rst_n, adv && in_last_r, out_v_r)

endmodule
